@@ rtl/pfvl_pkg.sv @@
package pfvl_pkg;

  localparam int KIND_W     = 1;
  localparam int COLUMN_W   = 7;
  localparam int ROW_W      = 8;
  localparam int DATA_W     = 8;
  localparam int PAGE_SEL_W = 3;

  // Clipped rows fit in 7 bits, so a page number derived from a row needs 4.
  localparam int Y_W    = ROW_W - 1;
  localparam int PAGE_W = Y_W - 3;

  localparam logic [KIND_W-1:0] KIND_DRAW = 1'b0;
  localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

  localparam logic [DATA_W-1:0] MASK_ALL = 8'hff;

endpackage

@@ rtl/pfvl_in_if.sv @@
interface pfvl_in_if;
  import pfvl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic        [KIND_W-1:0]      kind;
  logic        [COLUMN_W-1:0]    column;
  logic signed [ROW_W-1:0]       row_start;
  logic signed [ROW_W-1:0]       row_end;
  logic        [DATA_W-1:0]      fill_pattern;
  logic        [PAGE_SEL_W-1:0]  page_index;

  modport source (
    output valid, kind, column, row_start, row_end, fill_pattern, page_index,
    input  ready
  );

  modport sink (
    input  valid, kind, column, row_start, row_end, fill_pattern, page_index,
    output ready
  );

endinterface

@@ rtl/pfvl_out_if.sv @@
interface pfvl_out_if;
  import pfvl_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_data;
  logic                line_drawn;

  modport source (
    output valid, read_data, line_drawn,
    input  ready
  );

  modport sink (
    input  valid, read_data, line_drawn,
    output ready
  );

endinterface

@@ rtl/page_framebuffer_vline.sv @@
// Monochrome page frame store with a vertical line drawer. The store is one
// single-port-write, registered-read memory of SCREEN_WIDTH * (SCREEN_MAX_ROW / 8 + 1)
// bytes, and every pixel access goes through it. After reset the block runs a
// clearing pass that writes zero to every byte and accepts no item until it is
// done. Items are handled one at a time: a read item passes through ST_READ,
// where the registered memory output is captured, and then ST_DONE; a rejected
// draw goes straight to ST_DONE; and a draw that touches N page bytes (up to 8
// for a full-height line at the default size) does one memory read and one
// write per page byte before ST_DONE. The result sits in an output register,
// so the next item is taken while it waits to be picked up.
module page_framebuffer_vline #(
  parameter int SCREEN_WIDTH   = 128,
  parameter int SCREEN_MAX_ROW = 63
) (
  input logic       clk,
  input logic       rst,
  pfvl_in_if.sink   cmd,
  pfvl_out_if.source result
);
  import pfvl_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_MAX_ROW >> 3) + 1;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  localparam logic [ADDR_W-1:0] WIDTH_A    = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_BYTES - 1);
  localparam logic signed [ROW_W-1:0] MAX_ROW_S = ROW_W'(SCREEN_MAX_ROW);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_DONE
  } state_t;

  state_t               state;
  logic [ADDR_W-1:0]    clr_addr;
  logic [COLUMN_W-1:0]  col;
  logic [PAGE_W-1:0]    page;
  logic [PAGE_W-1:0]    last_page;
  logic [DATA_W-1:0]    top_mask;
  logic [DATA_W-1:0]    bot_mask;
  logic [DATA_W-1:0]    pattern;
  logic                 first;
  logic                 rd_ok;
  logic [DATA_W-1:0]    res_data;
  logic                 res_drawn;

  logic [DATA_W-1:0]    mem [STORE_BYTES];
  logic [DATA_W-1:0]    rdata;
  logic                 mem_we;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;
  logic [DATA_W-1:0]    wr_data;
  logic [DATA_W-1:0]    merge_mask;

  logic                 accept;
  logic                 col_ok;
  logic                 page_ok;
  logic                 reject;
  logic [Y_W-1:0]       y0;
  logic [Y_W-1:0]       y1;
  logic                 out_free;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [PAGE_W-1:0] pg,
                                                input logic [COLUMN_W-1:0] cl);
    return ADDR_W'(pg) * WIDTH_A + ADDR_W'(cl);
  endfunction

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !result.valid || result.ready;

  // Decode of the incoming item.
  always_comb begin
    col_ok  = (9'(cmd.column) < 9'(SCREEN_WIDTH));
    page_ok = (5'(cmd.page_index) < 5'(PAGE_COUNT));
    reject  = !col_ok || (cmd.row_end < cmd.row_start) || (cmd.row_end < 0)
              || (cmd.row_start > MAX_ROW_S);
    y0 = (cmd.row_start < 0) ? '0 : cmd.row_start[Y_W-1:0];
    y1 = (cmd.row_end > MAX_ROW_S) ? MAX_ROW_S[Y_W-1:0] : cmd.row_end[Y_W-1:0];
  end

  always_comb begin
    merge_mask = (first ? top_mask : MASK_ALL) & ((page == last_page) ? bot_mask : MASK_ALL);
    rd_addr    = (state == ST_IDLE) ? addr_of(PAGE_W'(cmd.page_index), cmd.column)
                                    : addr_of(page, col);
    mem_we     = (state == ST_CLEAR) || (state == ST_RMW_WR);
    wr_addr    = (state == ST_CLEAR) ? clr_addr : addr_of(page, col);
    wr_data    = (state == ST_CLEAR) ? '0
                                     : ((rdata & ~merge_mask) | (pattern & merge_mask));
  end

  // Frame store. A write-back also reads the byte it writes; that read returns
  // the old contents and is never used.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result.valid <= 1'b0;
    end else begin
      // The finishing state reloads the output register on its own.
      if (result.valid && result.ready && state != ST_DONE) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            col       <= cmd.column;
            pattern   <= cmd.fill_pattern;
            page      <= y0[Y_W-1:3];
            last_page <= y1[Y_W-1:3];
            top_mask  <= MASK_ALL << y0[2:0];
            bot_mask  <= MASK_ALL >> (3'd7 - y1[2:0]);
            first     <= 1'b1;
            rd_ok     <= col_ok && page_ok;
            res_data  <= '0;
            res_drawn <= 1'b0;
            if (cmd.kind == KIND_READ) begin
              state <= ST_READ;
            end else if (reject) begin
              state <= ST_DONE;
            end else begin
              state <= ST_RMW_RD;
            end
          end
        end
        ST_READ: begin
          res_data <= rd_ok ? rdata : '0;
          state    <= ST_DONE;
        end
        ST_RMW_RD: begin
          state <= ST_RMW_WR;
        end
        ST_RMW_WR: begin
          first <= 1'b0;
          if (page == last_page) begin
            res_drawn <= 1'b1;
            state     <= ST_DONE;
          end else begin
            page  <= page + 1'b1;
            state <= ST_RMW_RD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            result.valid      <= 1'b1;
            result.read_data  <= res_data;
            result.line_drawn <= res_drawn;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A write-back never runs past the last page of the line.
  a_page_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RMW_WR) |-> (page <= last_page))
    else $error("page write beyond the last page of the line");

  // A new result only appears when the finishing state hands it over.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the finishing state");

  // A waiting result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && result.valid && !result.ready) |=> (state == ST_DONE))
    else $error("finished item left while the output was still full");

endmodule
